>>> hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the mixed-radix index converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  localparam int PORTS           = 4;   // coordinate ports on the channels
  localparam int SIZE_W          = 16;  // width of a size register
  localparam int DIMC_W          = 3;   // width of the dimension count register
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_INDEX_WIDTH = 32;
  localparam int DEF_COORD_WIDTH = 16;

  localparam logic [DIMC_W-1:0] DIMC_RESET = 3'd4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_SIZE_0    = 3'd1,
    CFG_SIZE_1    = 3'd2,
    CFG_SIZE_2    = 3'd3,
    CFG_SIZE_3    = 3'd4
  } cfg_reg_t;

  // control bits carried along the cell chain
  typedef struct packed {
    logic vld;   // stage holds a word
    logic func;  // 0 fold coordinates, 1 split index
    logic err;   // out of range
    logic big;   // size product exceeds the index range
  } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mrc_if.sv
// ----------------------------------------------------------------------------
// mrc_in_if / mrc_out_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_in_if #(
  parameter int INDEX_WIDTH = mrc_pkg::DEF_INDEX_WIDTH,
  parameter int COORD_WIDTH = mrc_pkg::DEF_COORD_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [INDEX_WIDTH-1:0] index_in;
  logic [COORD_WIDTH-1:0] coord_0;
  logic [COORD_WIDTH-1:0] coord_1;
  logic [COORD_WIDTH-1:0] coord_2;
  logic [COORD_WIDTH-1:0] coord_3;

  modport source (output valid, func, index_in, coord_0, coord_1, coord_2, coord_3,
                  input ready);
  modport sink   (input valid, func, index_in, coord_0, coord_1, coord_2, coord_3,
                  output ready);
endinterface

interface mrc_out_if #(
  parameter int INDEX_WIDTH = mrc_pkg::DEF_INDEX_WIDTH,
  parameter int COORD_WIDTH = mrc_pkg::DEF_COORD_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [INDEX_WIDTH-1:0] index_out;
  logic [COORD_WIDTH-1:0] out_coord_0;
  logic [COORD_WIDTH-1:0] out_coord_1;
  logic [COORD_WIDTH-1:0] out_coord_2;
  logic [COORD_WIDTH-1:0] out_coord_3;
  logic                   range_error;

  modport source (output valid, index_out, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, range_error, input ready);
  modport sink   (input valid, index_out, out_coord_0, out_coord_1, out_coord_2,
                  out_coord_3, range_error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mrc_mac_cell.sv
// ----------------------------------------------------------------------------
// mrc_mac_cell
// One dimension of the fold: acc*size + coord, or the running size product.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_mac_cell #(
  parameter int IW  = mrc_pkg::DEF_INDEX_WIDTH,
  parameter int CW  = mrc_pkg::DEF_COORD_WIDTH,
  parameter int SW  = mrc_pkg::SIZE_W,
  parameter int NC  = mrc_pkg::PORTS,
  parameter int DIM = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 used,
  input  wire logic [SW-1:0]        sz,
  input  wire mrc_pkg::ctl_t        ctl_in,
  input  wire logic [IW-1:0]        x_in,
  input  wire logic [IW-1:0]        idx_in,
  input  wire logic [NC*CW-1:0]     cv_in,
  output mrc_pkg::ctl_t             ctl_out,
  output logic [IW-1:0]             x_out,
  output logic [IW-1:0]             idx_out,
  output logic [NC*CW-1:0]          cv_out
);

  localparam int PW = IW + SW + 1;

  logic [CW-1:0]  c;
  logic [SW-1:0]  sz_e;
  logic [SW-1:0]  c_e;
  logic [PW-1:0]  p;
  logic           ovf;
  mrc_pkg::ctl_t  ctl_next;
  logic [IW-1:0]  x_next;

  assign c    = cv_in[DIM*CW +: CW];
  assign sz_e = used ? sz : SW'(1);
  assign c_e  = (used && !ctl_in.func) ? c[SW-1:0] : '0;
  assign p    = PW'(x_in) * PW'(sz_e) + PW'(c_e);
  assign ovf  = |p[PW-1:IW];

  always_comb begin
    ctl_next = ctl_in;
    x_next   = x_in;
    if (!ctl_in.func) begin
      x_next = p[IW-1:0];
      if (used && ((c >= CW'(sz)) || ovf)) ctl_next.err = 1'b1;
    end else begin
      if (used && (sz == '0)) ctl_next.err = 1'b1;
      if (!ctl_in.big) begin
        if (ovf) ctl_next.big = 1'b1;
        else x_next = p[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out   <= x_next;
      idx_out <= idx_in;
      cv_out  <= cv_in;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mrc_div_cell.sv
// ----------------------------------------------------------------------------
// mrc_div_cell
// One restoring-division bit step; the last step of a digit stores its remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_div_cell #(
  parameter int IW   = mrc_pkg::DEF_INDEX_WIDTH,
  parameter int SW   = mrc_pkg::SIZE_W,
  parameter int NS   = mrc_pkg::PORTS,
  parameter int SLOT = 1,
  parameter bit LAST = 1'b0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [SW-1:0]     divisor,
  input  wire mrc_pkg::ctl_t     ctl_in,
  input  wire logic [IW-1:0]     q_in,
  input  wire logic [SW-1:0]     rem_in,
  input  wire logic [NS*SW-1:0]  side_in,
  output mrc_pkg::ctl_t          ctl_out,
  output logic [IW-1:0]          q_out,
  output logic [SW-1:0]          rem_out,
  output logic [NS*SW-1:0]       side_out
);

  logic [SW:0]      r2;
  logic             ge;
  logic [SW:0]      r3;
  logic [IW-1:0]    q_next;
  logic [SW-1:0]    rem_next;
  logic [NS*SW-1:0] side_next;

  assign r2 = {rem_in, q_in[IW-1]};
  assign ge = r2 >= {1'b0, divisor};
  assign r3 = ge ? (r2 - {1'b0, divisor}) : r2;

  always_comb begin
    q_next    = q_in;
    rem_next  = rem_in;
    side_next = side_in;
    if (ctl_in.func) begin
      q_next   = {q_in[IW-2:0], ge};
      rem_next = r3[SW-1:0];
      if (LAST) begin
        side_next[SLOT*SW +: SW] = r3[SW-1:0];
        rem_next                 = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out    <= q_next;
      rem_out  <= rem_next;
      side_out <= side_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mixed_radix_index_converter.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_converter
// Row-major linear index <-> per-dimension coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request words (func, index_in, coord_0..3), valid/ready.
//   rsp  : result words (index_out, out_coord_0..3, range_error), valid/ready.
//   wr_* : register writes (dim_count, size_0..size_3); write only while idle.
// Datapath is a row of cells moving one stage per cycle while not stalled:
//   - LIM multiply-add cells (LIM = min(MAX_DIMS,4)), one per dimension, fold
//     coordinates into the index or build the size product for the bound check;
//   - (LIM-1)*INDEX_WIDTH division cells, one quotient bit each, peel the
//     coordinates off the index, last dimension first.
// Throughput: one word per cycle while the skid register is empty, since
// the chain moves only then.
// Stall: a one-word skid register holds the finished word while rsp is not
// ready; the chain freezes only once that register is full, so req.ready is
// a registered signal.
// Reset: all stage valids and the skid clear; dim_count=4, sizes=1.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_index_converter #(
  parameter int MAX_DIMS    = mrc_pkg::DEF_MAX_DIMS,
  parameter int INDEX_WIDTH = mrc_pkg::DEF_INDEX_WIDTH,
  parameter int COORD_WIDTH = mrc_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [mrc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0] wr_data,
  mrc_in_if.sink                              req,
  mrc_out_if.source                           rsp
);

  localparam int NP   = mrc_pkg::PORTS;
  localparam int LIM  = (MAX_DIMS < NP) ? MAX_DIMS : NP;
  localparam int SW   = (COORD_WIDTH < mrc_pkg::SIZE_W) ? COORD_WIDTH : mrc_pkg::SIZE_W;
  localparam int IW   = INDEX_WIDTH;
  localparam int CW   = COORD_WIDTH;
  localparam int NDIV = LIM - 1;
  localparam int NST  = NDIV * IW;

  // ---- configuration registers ----
  logic [mrc_pkg::DIMC_W-1:0] dim_count;
  logic [mrc_pkg::SIZE_W-1:0] size_r [NP];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= mrc_pkg::DIMC_RESET;
      for (int i = 0; i < NP; i++) size_r[i] <= mrc_pkg::SIZE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        mrc_pkg::CFG_DIM_COUNT: dim_count <= wr_data[mrc_pkg::DIMC_W-1:0];
        mrc_pkg::CFG_SIZE_0:    size_r[0] <= wr_data[mrc_pkg::SIZE_W-1:0];
        mrc_pkg::CFG_SIZE_1:    size_r[1] <= wr_data[mrc_pkg::SIZE_W-1:0];
        mrc_pkg::CFG_SIZE_2:    size_r[2] <= wr_data[mrc_pkg::SIZE_W-1:0];
        mrc_pkg::CFG_SIZE_3:    size_r[3] <= wr_data[mrc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // dimension d is live when d==0 or dim_count>d (zero count acts as one,
  // counts past LIM saturate since d<LIM)
  logic [LIM-1:0] used;
  logic [SW-1:0]  sz [LIM];
  for (genvar d = 0; d < LIM; d++) begin : g_dim
    assign used[d] = (d == 0) || (dim_count > mrc_pkg::DIMC_W'(d));
    assign sz[d]   = size_r[d][SW-1:0];
  end

  // ---- flow control: chain moves whenever the skid register is empty ----
  logic skid_vld;
  logic en;
  assign en        = !skid_vld;
  assign req.ready = en;

  // ---- multiply-add cells ----
  logic [CW-1:0]     cin [NP];
  logic [LIM*CW-1:0] cv0;
  assign cin[0] = req.coord_0;
  assign cin[1] = req.coord_1;
  assign cin[2] = req.coord_2;
  assign cin[3] = req.coord_3;
  for (genvar d = 0; d < LIM; d++) begin : g_cv
    assign cv0[d*CW +: CW] = cin[d];
  end

  mrc_pkg::ctl_t     ctl_m [LIM+1];
  logic [IW-1:0]     x_m   [LIM+1];
  logic [IW-1:0]     idx_m [LIM+1];
  logic [LIM*CW-1:0] cv_m  [LIM+1];

  assign ctl_m[0] = '{vld: req.valid, func: req.func, err: 1'b0, big: 1'b0};
  assign x_m[0]   = req.func ? IW'(1) : '0;  // product seed or empty fold
  assign idx_m[0] = req.index_in;
  assign cv_m[0]  = cv0;

  for (genvar d = 0; d < LIM; d++) begin : g_mac
    mrc_mac_cell #(.IW(IW), .CW(CW), .SW(SW), .NC(LIM), .DIM(d)) u_mac (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .used    (used[d]),
      .sz      (sz[d]),
      .ctl_in  (ctl_m[d]),
      .x_in    (x_m[d]),
      .idx_in  (idx_m[d]),
      .cv_in   (cv_m[d]),
      .ctl_out (ctl_m[d+1]),
      .x_out   (x_m[d+1]),
      .idx_out (idx_m[d+1]),
      .cv_out  (cv_m[d+1])
    );
  end

  // ---- bound check between the two rows ----
  // split: index must stay below the size product unless that overflowed.
  // fold: the folded index rides the quotient lane untouched.
  mrc_pkg::ctl_t      ctl_d  [NST+1];
  logic [IW-1:0]      q_d    [NST+1];
  logic [SW-1:0]      rem_d  [NST+1];
  logic [LIM*SW-1:0]  side_d [NST+1];

  always_comb begin
    ctl_d[0] = ctl_m[LIM];
    if (ctl_m[LIM].func && !ctl_m[LIM].big && (idx_m[LIM] >= x_m[LIM]))
      ctl_d[0].err = 1'b1;
  end
  assign q_d[0]    = ctl_m[LIM].func ? idx_m[LIM] : x_m[LIM];
  assign rem_d[0]  = '0;
  assign side_d[0] = '0;

  // ---- division cells: digit j handles dimension LIM-1-j ----
  for (genvar k = 0; k < NST; k++) begin : g_div
    localparam int DIMK = LIM - 1 - (k / IW);
    localparam bit LST  = ((k % IW) == (IW - 1));
    logic [SW-1:0] dv;
    assign dv = used[DIMK] ? sz[DIMK] : SW'(1);

    mrc_div_cell #(.IW(IW), .SW(SW), .NS(LIM), .SLOT(DIMK), .LAST(LST)) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .divisor  (dv),
      .ctl_in   (ctl_d[k]),
      .q_in     (q_d[k]),
      .rem_in   (rem_d[k]),
      .side_in  (side_d[k]),
      .ctl_out  (ctl_d[k+1]),
      .q_out    (q_d[k+1]),
      .rem_out  (rem_d[k+1]),
      .side_out (side_d[k+1])
    );
  end

  // ---- result word ----
  mrc_pkg::ctl_t ctl_f;
  logic [IW-1:0] res_index;
  logic [CW-1:0] res_coord [NP];

  assign ctl_f = ctl_d[NST];

  always_comb begin
    res_index = '0;
    for (int i = 0; i < NP; i++) res_coord[i] = '0;
    if (!ctl_f.err) begin
      if (!ctl_f.func) begin
        res_index = q_d[NST];
      end else begin
        res_coord[0] = CW'(q_d[NST]);           // final quotient
        for (int i = 1; i < LIM; i++)
          res_coord[i] = CW'(side_d[NST][i*SW +: SW]);
      end
    end
  end

  // ---- skid register ----
  logic [IW-1:0] skid_index;
  logic [CW-1:0] skid_coord [NP];
  logic          skid_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (rsp.ready) skid_vld <= 1'b0;
    end else if (ctl_f.vld && !rsp.ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid_index <= res_index;
      skid_coord <= res_coord;
      skid_err   <= ctl_f.err;
    end
  end

  assign rsp.valid       = skid_vld || ctl_f.vld;
  assign rsp.index_out   = skid_vld ? skid_index    : res_index;
  assign rsp.out_coord_0 = skid_vld ? skid_coord[0] : res_coord[0];
  assign rsp.out_coord_1 = skid_vld ? skid_coord[1] : res_coord[1];
  assign rsp.out_coord_2 = skid_vld ? skid_coord[2] : res_coord[2];
  assign rsp.out_coord_3 = skid_vld ? skid_coord[3] : res_coord[3];
  assign rsp.range_error = skid_vld ? skid_err      : ctl_f.err;

  // ---- assertions ----
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.range_error |-> rsp.index_out == '0 &&
      rsp.out_coord_0 == '0 && rsp.out_coord_1 == '0 &&
      rsp.out_coord_2 == '0 && rsp.out_coord_3 == '0)
    else $error("range error word carries data");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.index_out != '0 |-> rsp.out_coord_0 == '0 &&
      rsp.out_coord_1 == '0 && rsp.out_coord_2 == '0 && rsp.out_coord_3 == '0)
    else $error("word has both index and coordinates");

  a_skid_freeze: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !rsp.ready |=> skid_vld && !req.ready)
    else $error("skid word dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

>>> verif/mixed_radix_index_converter_tb.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_converter_tb
// Self-checking bench for the row-major index converter. Request words are
// driven on the req channel, and a local predictor with its own copy of the
// registers works out the result for each accepted word. A checker compares
// every result word, field by field, with the oldest pending prediction.
// Both channels see random idle gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_index_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY_WAIT = 130;  // pipeline depth is 100 stages plus skid

  typedef struct {
    logic             func;
    logic [31:0]      index;
    logic [3:0][15:0] crd;
  } conv_word_t;

  typedef struct {
    logic [31:0]      index;
    logic [3:0][15:0] crd;
    logic             err;
  } conv_result_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [15:0] wr_data;

  mrc_in_if  req_if ();
  mrc_out_if rsp_if ();

  mixed_radix_index_converter dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // local copy of the register file
  logic [2:0]       dims_shadow;
  logic [3:0][15:0] size_shadow;

  conv_result_t pending_results[$];
  int           mismatches;
  bit           quiet;        // no gaps or stalls while set
  int           stall_left;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // -- Predictor -------------------------------------------------------------

  function automatic int dims_in_use();
    if (dims_shadow == 3'd0) return 1;
    if (dims_shadow > 3'd4) return 4;
    return int'(dims_shadow);
  endfunction

  // size product of the dims in use; 0 when a size is zero, saturates at 2^33
  function automatic logic [63:0] extent_product();
    logic [63:0] prod;
    prod = 64'd1;
    for (int i = 0; i < dims_in_use(); i++) begin
      if (size_shadow[i] == 16'd0) return 64'd0;
      prod = prod * 64'(size_shadow[i]);
      if (prod > 64'h1_0000_0000) prod = 64'h2_0000_0000;
    end
    return prod;
  endfunction

  function automatic conv_result_t convert_word(conv_word_t w);
    conv_result_t r;
    logic [63:0]  acc, prod, t, sz;
    logic         big;
    int           n;
    n = dims_in_use();
    r.index = '0;
    r.crd   = '0;
    r.err   = 1'b0;
    if (!w.func) begin
      // fold: Horner over dims in use, flag coord >= size or 32-bit overflow
      acc = 64'd0;
      for (int i = 0; i < n; i++) begin
        sz = 64'(size_shadow[i]);
        if (64'(w.crd[i]) >= sz) begin r.err = 1'b1; break; end
        if (acc > (64'hFFFF_FFFF - 64'(w.crd[i])) / sz) begin r.err = 1'b1; break; end
        acc = acc * sz + 64'(w.crd[i]);
      end
      if (!r.err) r.index = acc[31:0];
    end else begin
      prod = 64'd1;
      big  = 1'b0;
      for (int i = 0; i < n; i++) begin
        sz = 64'(size_shadow[i]);
        if (sz == 64'd0) begin r.err = 1'b1; break; end
        if (!big) begin
          if (prod > 64'hFFFF_FFFF / sz) big = 1'b1;
          else prod = prod * sz;
        end
      end
      // a product past the index range never flags
      if (!r.err && !big && 64'(w.index) >= prod) r.err = 1'b1;
      if (!r.err) begin
        t = 64'(w.index);
        for (int i = n - 1; i >= 1; i--) begin
          r.crd[i] = 16'(t % 64'(size_shadow[i]));
          t = t / 64'(size_shadow[i]);
        end
        r.crd[0] = t[15:0];
      end
    end
    return r;
  endfunction

  // -- Idle pattern ----------------------------------------------------------

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      rsp_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // -- Result checker --------------------------------------------------------
  // Sampled in the active region, so it sees pre-edge handshake values.

  always @(posedge clk) begin
    conv_result_t exp_r;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_if.index_out   !== exp_r.index  || rsp_if.out_coord_0 !== exp_r.crd[0] ||
            rsp_if.out_coord_1 !== exp_r.crd[1] || rsp_if.out_coord_2 !== exp_r.crd[2] ||
            rsp_if.out_coord_3 !== exp_r.crd[3] || rsp_if.range_error !== exp_r.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp idx=%h c=%h/%h/%h/%h err=%b got idx=%h c=%h/%h/%h/%h err=%b",
                     $realtime, exp_r.index, exp_r.crd[0], exp_r.crd[1], exp_r.crd[2],
                     exp_r.crd[3], exp_r.err, rsp_if.index_out, rsp_if.out_coord_0,
                     rsp_if.out_coord_1, rsp_if.out_coord_2, rsp_if.out_coord_3,
                     rsp_if.range_error);
        end
      end
    end
  end

  // -- Drivers ---------------------------------------------------------------

  task automatic send_word(conv_word_t w);
    int gap;
    req_if.valid    <= 1'b1;
    req_if.func     <= w.func;
    req_if.index_in <= w.index;
    req_if.coord_0  <= w.crd[0];
    req_if.coord_1  <= w.crd[1];
    req_if.coord_2  <= w.crd[2];
    req_if.coord_3  <= w.crd[3];
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(convert_word(w));
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic fold(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2, logic [15:0] c3);
    conv_word_t w;
    w.func  = 1'b0;
    w.index = $urandom;
    w.crd   = {c3, c2, c1, c0};
    send_word(w);
  endtask

  task automatic split(logic [31:0] index);
    conv_word_t w;
    w.func  = 1'b1;
    w.index = index;
    w.crd   = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    send_word(w);
  endtask

  // wait until the pipe is empty; registers may only change while idle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(mrc_pkg::cfg_reg_t reg_sel, logic [15:0] data);
    wr_en    <= 1'b1;
    wr_index <= reg_sel;
    wr_data  <= data;
    @(posedge clk);
    wr_en    <= 1'b0;
    case (reg_sel)
      mrc_pkg::CFG_DIM_COUNT: dims_shadow = data[2:0];
      mrc_pkg::CFG_SIZE_0:    size_shadow[0] = data;
      mrc_pkg::CFG_SIZE_1:    size_shadow[1] = data;
      mrc_pkg::CFG_SIZE_2:    size_shadow[2] = data;
      mrc_pkg::CFG_SIZE_3:    size_shadow[3] = data;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [15:0] dims, logic [15:0] s0, logic [15:0] s1,
                         logic [15:0] s2, logic [15:0] s3);
    cfg_write(mrc_pkg::CFG_DIM_COUNT, dims);
    cfg_write(mrc_pkg::CFG_SIZE_0, s0);
    cfg_write(mrc_pkg::CFG_SIZE_1, s1);
    cfg_write(mrc_pkg::CFG_SIZE_2, s2);
    cfg_write(mrc_pkg::CFG_SIZE_3, s3);
  endtask

  // -- Tests -----------------------------------------------------------------

  // after reset: four dims of size one, so only the origin is in range
  task automatic test_reset_state();
    fold(16'd0, 16'd0, 16'd0, 16'd0);
    fold(16'd1, 16'd0, 16'd0, 16'd0);
    fold(16'd0, 16'd0, 16'd0, 16'hFFFF);
    split(32'd0);
    split(32'd1);
    split(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_fold_extremes();
    cfg_all(16'd4, 16'd16, 16'd16, 16'd256, 16'd65535);
    fold(16'd15, 16'd15, 16'd255, 16'd65534);   // top of the space
    fold(16'd15, 16'd16, 16'd0, 16'd0);         // coord equal to its size
    split(32'hFFFF_FFFF);
    split(32'hFFFF_FFFE);
    drain();
    // product past 2^32: fold overflows, split never flags
    cfg_all(16'hFFFC, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
    fold(16'd65534, 16'd65534, 16'd65534, 16'd65534);
    fold(16'd0, 16'd0, 16'd1, 16'd0);
    split(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_single_dim();
    cfg_all(16'd1, 16'd65535, 16'd3, 16'd3, 16'd3);
    split(32'd65534);
    split(32'd65535);
    fold(16'd65534, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // unused coords ignored
    drain();
    cfg_write(mrc_pkg::CFG_DIM_COUNT, 16'd0);       // zero counts as one dim
    split(32'd100);
    fold(16'hFFFF, 16'd0, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_zero_size_and_saturation();
    cfg_all(16'd2, 16'd7, 16'd0, 16'd5, 16'd5);
    fold(16'd1, 16'd0, 16'd0, 16'd0);
    split(32'd0);
    drain();
    cfg_all(16'd7, 16'd3, 16'd5, 16'd7, 16'd11);    // saturates to four dims
    split(32'd1154);
    fold(16'd2, 16'd4, 16'd6, 16'd10);
    drain();
  endtask

  function automatic logic [15:0] random_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16'($urandom_range(1, 8));
    if (roll < 70) return 16'($urandom_range(9, 300));
    if (roll < 80) return 16'd65535;
    if (roll < 97) return 16'($urandom);
    return 16'd0;
  endfunction

  function automatic conv_word_t random_word();
    conv_word_t  w;
    logic [63:0] prod;
    w.func  = 1'($urandom_range(0, 1));
    w.index = $urandom;
    w.crd   = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    // mostly in range, the rest raw noise
    if ($urandom_range(0, 99) < 80) begin
      if (!w.func) begin
        for (int i = 0; i < 4; i++)
          if (size_shadow[i] != 0) w.crd[i] = 16'($urandom % size_shadow[i]);
      end else begin
        prod = extent_product();
        if (prod != 0 && prod <= 64'hFFFF_FFFF) begin
          w.index = 32'({$urandom, $urandom} % prod);
          if ($urandom_range(0, 9) == 0) w.index = 32'(prod - 1);
        end
      end
    end
    return w;
  endfunction

  task automatic test_random_phases();
    logic [15:0] dims;
    for (int phase = 0; phase < 13; phase++) begin
      quiet = ($urandom_range(0, 3) == 0);
      dims  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      cfg_all(dims, random_size(), random_size(), random_size(), random_size());
      repeat (110) send_word(random_word());
      drain();
    end
    quiet = 1'b0;
  endtask

  // -- Sequence --------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = '0;
    wr_data         = '0;
    req_if.valid    = 1'b0;
    req_if.func     = 1'b0;
    req_if.index_in = '0;
    req_if.coord_0  = '0;
    req_if.coord_1  = '0;
    req_if.coord_2  = '0;
    req_if.coord_3  = '0;
    dims_shadow     = mrc_pkg::DIMC_RESET;
    size_shadow     = {4{mrc_pkg::SIZE_RESET}};
    mismatches      = 0;
    quiet           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_fold_extremes();
    test_single_dim();
    test_zero_size_and_saturation();
    test_random_phases();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
